@@ sv/mjc_pkg.sv @@
// mjc_pkg: shared types for the minimum jump count block
// sequencer states and the result request; no dependencies
package mjc_pkg;

	localparam int unsigned JL_W  = 8;
	localparam int unsigned CNT_W = 8;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} mjc_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] jump_count;
		logic             unreachable;
		logic             overflow;
	} mjc_res_t;

endpackage

@@ sv/mjc_if.sv @@
// mjc_in_if and mjc_out_if: valid/ready channels for items and results
// field widths come from mjc_pkg
interface mjc_in_if;
	import mjc_pkg::*;
	logic            valid;
	logic            ready;
	logic [JL_W-1:0] jump_length;
	logic            last_item;

	modport source (output valid, jump_length, last_item, input ready);
	modport sink (input valid, jump_length, last_item, output ready);
endinterface

interface mjc_out_if;
	import mjc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] jump_count;
	logic             unreachable;
	logic             overflow;

	modport source (output valid, jump_count, unreachable, overflow, input ready);
	modport sink (input valid, jump_count, unreachable, overflow, output ready);
endinterface

@@ sv/mjc_ram.sv @@
// mjc_ram: generic single write port, single read port ram
// read data registered; no dependencies
module mjc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/mjc_out.sv @@
// mjc_out: result register between the sequencer and the result channel
// depends on mjc_pkg and mjc_if
module mjc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  mjc_pkg::mjc_res_t res,
	output logic              res_ready,
	mjc_out_if.source         result
);
	import mjc_pkg::*;

	logic     valid_q;
	mjc_res_t data_q;

	assign res_ready = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign result.valid       = valid_q;
	assign result.jump_count  = data_q.jump_count;
	assign result.unreachable = data_q.unreachable;
	assign result.overflow    = data_q.overflow;

endmodule

@@ sv/mjc_ctrl.sv @@
// mjc_ctrl: load sequencer and table walk over the jump and count rams
// depends on mjc_pkg and mjc_if; rams sit in the top level
module mjc_ctrl #(
	parameter int unsigned MAX_LEN   = 256,
	parameter int unsigned JUMP_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mjc_in_if.sink                     item,
	output logic                       jmp_we,
	output logic [$clog2(MAX_LEN)-1:0] jmp_waddr,
	output logic [JUMP_BITS-1:0]       jmp_wdata,
	output logic [$clog2(MAX_LEN)-1:0] rd_addr,
	input  logic [JUMP_BITS-1:0]       jmp_rdata,
	output logic                       cnt_we,
	output logic [$clog2(MAX_LEN)-1:0] cnt_waddr,
	output logic [$clog2(MAX_LEN)-1:0] cnt_wdata,
	input  logic [$clog2(MAX_LEN)-1:0] cnt_rdata,
	output logic                       res_valid,
	output mjc_pkg::mjc_res_t          res,
	input  logic                       res_ready
);
	import mjc_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_LEN);
	localparam int unsigned LC_W   = ADDR_W + 1;
	localparam int unsigned SUM_W  = ((ADDR_W > JUMP_BITS) ? ADDR_W : JUMP_BITS) + 1;
	localparam int unsigned WIDE_W = ADDR_W + CNT_W;

	mjc_state_t        state_q, state_d;
	logic [LC_W-1:0]   load_count_q;
	logic              too_many_q;
	logic [ADDR_W-1:0] pos_q, from_q, lastpos_q;
	mjc_res_t          res_q;

	logic              in_ready;
	logic              accept;
	logic              full;
	logic              ovf_now;
	logic              reach;
	logic [ADDR_W-1:0] cnt_inc;
	logic [ADDR_W-1:0] from_inc;
	logic [WIDE_W-1:0] cnt_wide;
	logic [CNT_W-1:0]  cnt_sat;

	assign accept   = item.valid && in_ready;
	assign full     = load_count_q == LC_W'(MAX_LEN);
	assign ovf_now  = too_many_q || full;
	assign reach    = (SUM_W'(from_q) + SUM_W'(jmp_rdata)) >= SUM_W'(pos_q);
	assign cnt_inc  = cnt_rdata + ADDR_W'(1);
	assign from_inc = from_q + ADDR_W'(1);
	assign cnt_wide = WIDE_W'(cnt_inc);
	assign cnt_sat  = (cnt_wide > WIDE_W'(255)) ? {CNT_W{1'b1}} : CNT_W'(cnt_wide);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && item.last_item) begin
					state_d = (ovf_now || load_count_q == '0) ? ST_EMIT : ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (reach) begin
					state_d = (pos_q == lastpos_q) ? ST_EMIT : ST_READ;
				end else begin
					state_d = (from_inc == pos_q) ? ST_EMIT : ST_READ;
				end
			end
			ST_EMIT: begin
				if (res_ready) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		jmp_we    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = pos_q;
		cnt_wdata = cnt_inc;
		res_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				jmp_we   = accept && !full;
				if (accept && item.last_item) begin
					cnt_we    = 1'b1;
					cnt_waddr = '0;
					cnt_wdata = '0;
				end
			end
			ST_READ: ;
			ST_EVAL: cnt_we = reach;
			ST_EMIT: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign item.ready = in_ready;
	assign jmp_waddr  = load_count_q[ADDR_W-1:0];
	assign jmp_wdata  = JUMP_BITS'(item.jump_length);
	assign rd_addr    = from_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			too_many_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (full) begin
					too_many_q <= 1'b1;
				end else begin
					load_count_q <= load_count_q + LC_W'(1);
				end
			end
			if (state_q == ST_EMIT && res_ready) begin
				load_count_q <= '0;
				too_many_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (accept && item.last_item) begin
					pos_q     <= ADDR_W'(1);
					from_q    <= '0;
					lastpos_q <= load_count_q[ADDR_W-1:0];
					res_q     <= '{jump_count: '0, unreachable: 1'b0, overflow: ovf_now};
				end
			end
			ST_EVAL: begin
				if (reach) begin
					pos_q <= pos_q + ADDR_W'(1);
					res_q <= '{jump_count: cnt_sat, unreachable: 1'b0, overflow: 1'b0};
				end else begin
					from_q <= from_inc;
					res_q  <= '{jump_count: '0, unreachable: 1'b1, overflow: 1'b0};
				end
			end
			default: ;
		endcase
	end

	a_from_below_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> from_q < pos_q)
		else $error("walk pointer passed current position");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> pos_q <= lastpos_q)
		else $error("position beyond last element");

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_READ)
		else $error("evaluation without a ram read");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q <= LC_W'(MAX_LEN))
		else $error("load count above capacity");

endmodule

@@ sv/min_jump_count_dp.sv @@
// min_jump_count_dp: minimum jump count over a loaded array, top level
// depends on mjc_pkg, mjc_if, mjc_ram, mjc_ctrl and mjc_out
//
//   channel  dir  fields                                  request
//   item     in   jump_length[7:0], last_item             one array element
//   result   out  jump_count[7:0], unreachable, overflow  one per last element
//
// loading takes one element per cycle
// after the last element the walk takes a ram read, then an evaluate, per step,
// at most 2*(len-1) steps before the result
// item is held off during the walk and while a finished result waits for the result register
// a result waiting on the output does not block elements of the next array
// reset clears control state only; ram contents are written before they are read
module min_jump_count_dp #(
	parameter int unsigned MAX_LEN   = 256,
	parameter int unsigned JUMP_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	mjc_in_if.sink    item,
	mjc_out_if.source result
);
	import mjc_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_LEN);

	logic                 jmp_we;
	logic [ADDR_W-1:0]    jmp_waddr;
	logic [JUMP_BITS-1:0] jmp_wdata;
	logic [JUMP_BITS-1:0] jmp_rdata;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 cnt_we;
	logic [ADDR_W-1:0]    cnt_waddr;
	logic [ADDR_W-1:0]    cnt_wdata;
	logic [ADDR_W-1:0]    cnt_rdata;
	logic                 res_valid;
	logic                 res_ready;
	mjc_res_t             res;

	mjc_ram #(
		.WIDTH(JUMP_BITS),
		.DEPTH(MAX_LEN)
	) u_jump_ram (
		.clk  (clk),
		.we   (jmp_we),
		.waddr(jmp_waddr),
		.wdata(jmp_wdata),
		.raddr(rd_addr),
		.rdata(jmp_rdata)
	);

	mjc_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(MAX_LEN)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(rd_addr),
		.rdata(cnt_rdata)
	);

	mjc_ctrl #(
		.MAX_LEN  (MAX_LEN),
		.JUMP_BITS(JUMP_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.jmp_we   (jmp_we),
		.jmp_waddr(jmp_waddr),
		.jmp_wdata(jmp_wdata),
		.rd_addr  (rd_addr),
		.jmp_rdata(jmp_rdata),
		.cnt_we   (cnt_we),
		.cnt_waddr(cnt_waddr),
		.cnt_wdata(cnt_wdata),
		.cnt_rdata(cnt_rdata),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready)
	);

	mjc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.result   (result)
	);

endmodule

@@ bench/min_jump_count_dp_test.sv @@
// min_jump_count_dp_test: self-checking bench for the minimum jump count block
// directed table, then random arrays with idling, a long result hold-off and overflow
// depends on mjc_pkg, mjc_if and min_jump_count_dp
module min_jump_count_dp_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mjc_pkg::*;

	localparam int unsigned MAX_LEN    = 256;
	localparam int unsigned ITEM_GOAL  = 900;
	localparam int unsigned HOLD_LEN   = 400;
	localparam int unsigned DRAIN_WAIT = 4 * MAX_LEN + 64;
	localparam int unsigned STALL_MAX  = 8000;
	localparam int unsigned N_DIRECTED = 25;

	typedef struct packed {
		logic [JL_W-1:0] jl;
		logic            last;
		logic            chk;
		mjc_res_t        exp;
	} elem_t;

	localparam elem_t DIRECTED [N_DIRECTED] = '{
		'{8'd0,   1'b1, 1'b1, '{8'd0, 1'b0, 1'b0}},
		'{8'd255, 1'b1, 1'b1, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd5,   1'b1, 1'b1, '{8'd0, 1'b1, 1'b0}},
		'{8'd255, 1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b1, 1'b1, '{8'd1, 1'b0, 1'b0}},
		'{8'd1,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd1,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd1,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b1, 1'b1, '{8'd3, 1'b0, 1'b0}},
		'{8'd2,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd7,   1'b1, 1'b1, '{8'd1, 1'b0, 1'b0}},
		'{8'd1,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b1, 1'b1, '{8'd0, 1'b1, 1'b0}},
		'{8'd3,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd1,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd2,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd9,   1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b1, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd128, 1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd64,  1'b0, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{8'd32,  1'b1, 1'b0, '{8'd0, 1'b0, 1'b0}}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mjc_in_if  item();
	mjc_out_if result();

	min_jump_count_dp #(
		.MAX_LEN  (MAX_LEN),
		.JUMP_BITS(JL_W)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	elem_t           elem_q[$];
	mjc_res_t        answer_q[$];
	logic [JL_W-1:0] load_buf[MAX_LEN];
	int unsigned     load_len  = 0;
	bit              load_ovf  = 1'b0;
	bit              steady    = 1'b0;
	int unsigned     hold_asked  = 0;
	int unsigned     hold_served = 0;
	int unsigned     fail_cnt    = 0;
	int unsigned     quiet_cycles = 0;

	function automatic mjc_res_t solve_jumps(int unsigned len);
		mjc_res_t    r;
		bit          reach[MAX_LEN];
		int unsigned hops[MAX_LEN];
		int unsigned p;
		int unsigned f;
		reach[0] = 1'b1;
		hops[0]  = 0;
		for (p = 1; p < len; p++) begin
			reach[p] = 1'b0;
			hops[p]  = 0;
			for (f = 0; f < p; f++) begin
				if (reach[f] && p <= f + load_buf[f]) begin
					hops[p]  = hops[f] + 1;
					reach[p] = 1'b1;
					break;
				end
			end
		end
		r.overflow = 1'b0;
		if (reach[len-1]) begin
			r.jump_count  = (hops[len-1] > 255) ? 8'd255 : hops[len-1][CNT_W-1:0];
			r.unreachable = 1'b0;
		end else begin
			r.jump_count  = '0;
			r.unreachable = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [JL_W-1:0] pick_jump(int unsigned len);
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return JL_W'($urandom_range(3));
		else if (sel < 8)
			return JL_W'($urandom_range(len));
		else
			return JL_W'($urandom_range(255));
	endfunction

	task automatic push_elem(logic [JL_W-1:0] jl, logic last);
		elem_t e;
		e.jl   = jl;
		e.last = last;
		e.chk  = 1'b0;
		e.exp  = '0;
		elem_q.push_back(e);
	endtask

	// request source and predictor
	initial begin : item_side
		elem_t cur;
		item.valid       = 1'b0;
		item.jump_length = '0;
		item.last_item   = 1'b0;
		cur              = '0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (item.valid && item.ready) begin
				if (load_len < MAX_LEN) begin
					load_buf[load_len] = cur.jl;
					load_len++;
				end else begin
					load_ovf = 1'b1;
				end
				if (cur.last) begin
					if (cur.chk)
						answer_q.push_back(cur.exp);
					else if (load_ovf)
						answer_q.push_back('{8'd0, 1'b0, 1'b1});
					else
						answer_q.push_back(solve_jumps(load_len));
					load_len = 0;
					load_ovf = 1'b0;
				end
			end
			if (!item.valid || item.ready) begin
				if (elem_q.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
					cur = elem_q.pop_front();
					item.valid       <= 1'b1;
					item.jump_length <= cur.jl;
					item.last_item   <= cur.last;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	initial begin : result_side
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				result.ready <= 1'b0;
				hold_served++;
				repeat (HOLD_LEN - 1) @(posedge clk);
			end else begin
				result.ready <= steady || $urandom_range(99) >= 28;
			end
		end
	end

	always @(posedge clk) begin
		mjc_res_t want;
		if (arst_n && result.valid && result.ready) begin
			if (answer_q.size() == 0) begin
				$error("result with no request pending: jump_count %0d unreachable %0b overflow %0b",
					result.jump_count, result.unreachable, result.overflow);
				fail_cnt++;
			end else begin
				want = answer_q.pop_front();
				if (result.jump_count !== want.jump_count) begin
					$error("jump_count: expected %0d, actual %0d", want.jump_count,
						result.jump_count);
					fail_cnt++;
				end
				if (result.unreachable !== want.unreachable) begin
					$error("unreachable: expected %0b, actual %0b", want.unreachable,
						result.unreachable);
					fail_cnt++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0b, actual %0b", want.overflow,
						result.overflow);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("** min_jump_count_dp: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned i;
		int unsigned k;
		int unsigned len;
		int unsigned sent;
		int unsigned arrays;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_DIRECTED; i++)
			elem_q.push_back(DIRECTED[i]);

		// longest array, one step per position
		for (k = 0; k < MAX_LEN; k++)
			push_elem(8'd1, k == MAX_LEN - 1);
		// one past the limit
		for (k = 0; k <= MAX_LEN; k++)
			push_elem(pick_jump(16), k == MAX_LEN);
		sent   = N_DIRECTED + 2 * MAX_LEN + 1;
		arrays = 0;

		while (sent < ITEM_GOAL) begin
			while (elem_q.size() > 8) @(posedge clk);
			if (arrays == 6)
				hold_asked++;
			steady = (arrays >= 20 && arrays < 34);
			len = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
			for (k = 0; k < len; k++)
				push_elem(pick_jump(len), k == len - 1);
			sent += len;
			arrays++;
		end
		steady = 1'b0;

		while (elem_q.size() != 0 || item.valid) @(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0)
			$display("** min_jump_count_dp: PASSED **");
		else
			$display("** min_jump_count_dp: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
sv/mjc_pkg.sv
sv/mjc_if.sv
sv/mjc_ram.sv
sv/mjc_out.sv
sv/mjc_ctrl.sv
sv/min_jump_count_dp.sv
bench/min_jump_count_dp_test.sv
